>>> src/rwc_pkg.sv
package rwc_pkg;

   localparam int KernelHeight = 5;
   localparam int KernelWidth  = 5;
   localparam int Taps         = KernelHeight * KernelWidth;
   localparam int MaxWidth     = 1024;
   localparam int MaxHeight    = 4096;
   localparam int CoefFracBits = 16;
   localparam int CoefW        = 16;
   localparam int ChanW        = 8;
   localparam int PixW         = 3 * ChanW;
   localparam int ColW         = 10;
   localparam int RowW         = 12;
   localparam int WidthRegW    = 11;
   localparam int HeightRegW   = 13;
   localparam int AddrW        = $clog2(MaxWidth);
   localparam int TapIdxW      = 5;
   localparam int ProdW        = CoefW + ChanW;
   localparam int RowSumW      = ProdW + $clog2(KernelWidth);
   localparam int SumW         = ProdW + $clog2(Taps);
   localparam int QueueDepth   = 4;
   localparam int QueuePtrW    = $clog2(QueueDepth);
   localparam int QueueCntW    = $clog2(QueueDepth + 1);

   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_PIXEL = 1'b1
   } cmd_type;

   typedef enum logic {
      REG_WIDTH  = 1'b0,
      REG_HEIGHT = 1'b1
   } reg_type;

   typedef logic [PixW-1:0] pix_type;
   typedef pix_type [KernelHeight-2:0] line_word_type;
   typedef pix_type [KernelHeight-1:0][KernelWidth-1:0] window_type;

   typedef struct packed {
      window_type window;
      logic       last;
   } entry_type;

   typedef struct packed {
      logic                 en;
      logic [TapIdxW-1:0]   idx;
      logic [CoefW-1:0]     value;
   } coef_wr_type;

endpackage

>>> src/rgb_window_convolution_valid.sv
// rgb window convolution, valid mode
// req channel: one request is a pixel or a kernel coefficient load, chosen by
//   req_tuser; a pixel arrives in raster order, a load writes one tap of the
//   5x5 coefficient table (unsigned q0.16, row times 5 plus column)
// rsp channel: one filtered pixel per window that lies fully inside the
//   image, raster order, rsp_tlast on the last one of the frame; each
//   channel is the weighted sum shifted right by 16 and saturated to 255
// csr port: index 0 sets the image width, index 1 the height; write only
//   while the block is idle
// latency: a pixel request accepted at one edge shows its result on rsp
//   four edges later when the receiver does not stall
// throughput: one pixel per cycle, set by the line store with one read and
//   one write port, read at acceptance and written in the following cycle; a
//   coefficient load waits until no pixel is in flight ahead of the multiplier stage
// reset: counters, window and control clear; width and height return to
//   1024; coefficient table and line store keep whatever they held
// stall: a four-entry queue between the line store side and the multiply
//   tree takes up back pressure; requests stop only when it could fill up
module rgb_window_convolution_valid (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [47:0]                        req_tdata,  // coef_index, coef_value, red_in, green_in, blue_in
   input  logic                               req_tuser,  // command
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [23:0]                        rsp_tdata,  // red_out, green_out, blue_out
   output logic                               rsp_tlast,  // frame_last
   input  logic                               csr_we,
   input  logic                               csr_addr,
   input  logic [rwc_pkg::HeightRegW-1:0]     csr_wdata
);

   logic [rwc_pkg::WidthRegW-1:0]  width_ff;
   logic [rwc_pkg::HeightRegW-1:0] height_ff;
   logic [rwc_pkg::WidthRegW-1:0]  wval;
   logic [rwc_pkg::HeightRegW-1:0] hval;

   logic                           accept, is_pixel, front_busy;
   logic                           push, q_valid, q_pop;
   rwc_pkg::entry_type             push_entry, q_head;
   logic [rwc_pkg::QueueCntW-1:0]  q_count;
   logic [rwc_pkg::QueueCntW:0]    in_flight;
   rwc_pkg::coef_wr_type           coef_wr;
   rwc_pkg::pix_type               pix;

   // register writes, zero acts as one and large values clamp
   always_comb begin
      wval = csr_wdata[rwc_pkg::WidthRegW-1:0];
      hval = csr_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rwc_pkg::WidthRegW'(rwc_pkg::MaxWidth);
         height_ff <= rwc_pkg::HeightRegW'(1024);
      end else if (csr_we) begin
         if (rwc_pkg::reg_type'(csr_addr) == rwc_pkg::REG_WIDTH) begin
            if (wval == '0) begin
               width_ff <= rwc_pkg::WidthRegW'(1);
            end else if (wval > rwc_pkg::WidthRegW'(rwc_pkg::MaxWidth)) begin
               width_ff <= rwc_pkg::WidthRegW'(rwc_pkg::MaxWidth);
            end else begin
               width_ff <= wval;
            end
         end else begin
            if (hval == '0) begin
               height_ff <= rwc_pkg::HeightRegW'(1);
            end else if (hval > rwc_pkg::HeightRegW'(rwc_pkg::MaxHeight)) begin
               height_ff <= rwc_pkg::HeightRegW'(rwc_pkg::MaxHeight);
            end else begin
               height_ff <= hval;
            end
         end
      end
   end

   assign is_pixel  = (rwc_pkg::cmd_type'(req_tuser) == rwc_pkg::CMD_PIXEL);
   assign in_flight = {1'b0, q_count} + {{rwc_pkg::QueueCntW{1'b0}}, front_busy};

   // pixels need room in the queue; a load must not overtake a queued pixel
   always_comb begin
      if (reset) begin
         req_tready = 1'b0;
      end else if (is_pixel) begin
         req_tready = in_flight < (rwc_pkg::QueueCntW+1)'(rwc_pkg::QueueDepth);
      end else begin
         req_tready = (in_flight == '0);
      end
   end

   assign accept        = req_tvalid && req_tready;
   assign coef_wr.en    = accept && !is_pixel;
   assign coef_wr.idx   = req_tdata[4:0];
   assign coef_wr.value = req_tdata[20:5];
   assign pix           = {req_tdata[28:21], req_tdata[36:29], req_tdata[44:37]};

   rwc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .pix_en     (accept && is_pixel),
      .pix        (pix),
      .width      (width_ff),
      .height     (height_ff),
      .busy       (front_busy),
      .push       (push),
      .push_entry (push_entry)
   );

   rwc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .valid      (q_valid),
      .head       (q_head),
      .count      (q_count)
   );

   rwc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .coef_wr    (coef_wr),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .out_valid  (rsp_tvalid),
      .out_data   (rsp_tdata),
      .out_last   (rsp_tlast),
      .out_ready  (rsp_tready)
   );

endmodule

>>> src/rwc_front.sv
module rwc_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 pix_en,
   input  rwc_pkg::pix_type                     pix,
   input  logic [rwc_pkg::WidthRegW-1:0]        width,
   input  logic [rwc_pkg::HeightRegW-1:0]       height,
   output logic                                 busy,
   output logic                                 push,
   output rwc_pkg::entry_type                   push_entry
);

   logic [rwc_pkg::ColW-1:0]   col_ff, col_in;
   logic [rwc_pkg::RowW-1:0]   row_ff, row_in;
   logic                       emit, last;

   logic                       a_v_ff, a_v_in;
   rwc_pkg::pix_type           a_pix_ff;
   logic [rwc_pkg::AddrW-1:0]  a_col_ff;
   logic                       a_emit_ff;
   logic                       a_last_ff;

   rwc_pkg::line_word_type     mem [rwc_pkg::MaxWidth];
   rwc_pkg::line_word_type     rd_ff;
   logic                       byp_ff;
   rwc_pkg::line_word_type     byp_data_ff;
   rwc_pkg::line_word_type     line_rd, wdata;

   rwc_pkg::pix_type [rwc_pkg::KernelHeight-1:0] vec;
   rwc_pkg::window_type        win_ff, win_in;

   // position of the incoming pixel and its window test
   always_comb begin
      emit = ({1'b0, col_ff} < width) && ({1'b0, row_ff} < height) &&
             (col_ff >= rwc_pkg::ColW'(rwc_pkg::KernelWidth - 1)) &&
             (row_ff >= rwc_pkg::RowW'(rwc_pkg::KernelHeight - 1));
      last = ({1'b0, col_ff} == width - 1'b1) && ({1'b0, row_ff} == height - 1'b1);
      col_in = col_ff;
      row_in = row_ff;
      if (pix_en) begin
         if ({1'b0, col_ff} + 1'b1 >= width) begin
            col_in = '0;
            if ({1'b0, row_ff} + 1'b1 >= height) begin
               row_in = '0;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   assign a_v_in = pix_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         a_v_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         a_v_ff <= a_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_en) begin
         a_pix_ff    <= pix;
         a_col_ff    <= col_ff;
         a_emit_ff   <= emit;
         a_last_ff   <= last;
         // same column written at this edge: take the write data directly
         byp_ff      <= a_v_ff && (a_col_ff == col_ff);
         byp_data_ff <= wdata;
      end
   end

   // line store, one word holds a column of the older rows
   always_ff @(posedge clock) begin
      if (a_v_ff) begin
         mem[a_col_ff] <= wdata;
      end
      if (pix_en) begin
         rd_ff <= mem[col_ff];
      end
   end

   always_comb begin
      line_rd = byp_ff ? byp_data_ff : rd_ff;
      for (int r = 0; r < rwc_pkg::KernelHeight - 1; r++) begin
         vec[r] = line_rd[r];
      end
      vec[rwc_pkg::KernelHeight-1] = a_pix_ff;
      for (int r = 0; r < rwc_pkg::KernelHeight - 1; r++) begin
         wdata[r] = vec[r+1];
      end
      win_in = win_ff;
      if (a_v_ff) begin
         for (int r = 0; r < rwc_pkg::KernelHeight; r++) begin
            for (int c = 0; c < rwc_pkg::KernelWidth - 1; c++) begin
               win_in[r][c] = win_ff[r][c+1];
            end
            win_in[r][rwc_pkg::KernelWidth-1] = vec[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else begin
         win_ff <= win_in;
      end
   end

   assign busy              = a_v_ff;
   assign push              = a_v_ff && a_emit_ff;
   assign push_entry.window = win_in;
   assign push_entry.last   = a_last_ff;

endmodule

>>> src/rwc_queue.sv
module rwc_queue (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   input  rwc_pkg::entry_type                 push_entry,
   input  logic                               pop,
   output logic                               valid,
   output rwc_pkg::entry_type                 head,
   output logic [rwc_pkg::QueueCntW-1:0]      count
);

   rwc_pkg::entry_type                 slot_ff [rwc_pkg::QueueDepth];
   logic [rwc_pkg::QueuePtrW-1:0]      wr_ff, wr_in;
   logic [rwc_pkg::QueuePtrW-1:0]      rd_ff, rd_in;
   logic [rwc_pkg::QueueCntW-1:0]      cnt_ff, cnt_in;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + {{(rwc_pkg::QueueCntW-1){1'b0}}, push}
                      - {{(rwc_pkg::QueueCntW-1){1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

   assign valid = (cnt_ff != '0);
   assign head  = slot_ff[rd_ff];
   assign count = cnt_ff;

endmodule

>>> src/rwc_back.sv
module rwc_back (
   input  logic                       clock,
   input  logic                       reset,
   input  rwc_pkg::coef_wr_type       coef_wr,
   input  logic                       q_valid,
   input  rwc_pkg::entry_type         q_head,
   output logic                       q_pop,
   output logic                       out_valid,
   output logic [rwc_pkg::PixW-1:0]   out_data,
   output logic                       out_last,
   input  logic                       out_ready
);

   localparam int Kh = rwc_pkg::KernelHeight;
   localparam int Kw = rwc_pkg::KernelWidth;

   logic [rwc_pkg::CoefW-1:0] coef_ff [rwc_pkg::Taps];

   logic en;
   logic m_v_ff, s_v_ff, o_v_ff;
   logic m_last_ff, s_last_ff, o_last_ff;
   logic [2:0][Kh-1:0][Kw-1:0][rwc_pkg::ProdW-1:0]  prod_in, prod_ff;
   logic [2:0][Kh-1:0][rwc_pkg::RowSumW-1:0]         rsum_in, rsum_ff;
   logic [2:0][rwc_pkg::ChanW-1:0]                   res_in, res_ff;
   logic [rwc_pkg::SumW-1:0]                         total;
   logic [rwc_pkg::SumW-rwc_pkg::CoefFracBits-1:0]   scaled;

   always_ff @(posedge clock) begin
      if (coef_wr.en && (coef_wr.idx < rwc_pkg::TapIdxW'(rwc_pkg::Taps))) begin
         coef_ff[coef_wr.idx] <= coef_wr.value;
      end
   end

   assign en    = !o_v_ff || out_ready;
   assign q_pop = en && q_valid;

   // channel 0 is blue, 1 green, 2 red
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         for (int r = 0; r < Kh; r++) begin
            for (int c = 0; c < Kw; c++) begin
               prod_in[ch][r][c] = rwc_pkg::ProdW'(coef_ff[r*Kw + c]) *
                  rwc_pkg::ProdW'(q_head.window[r][c][ch*rwc_pkg::ChanW +: rwc_pkg::ChanW]);
            end
         end
      end
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         for (int r = 0; r < Kh; r++) begin
            rsum_in[ch][r] = '0;
            for (int c = 0; c < Kw; c++) begin
               rsum_in[ch][r] = rsum_in[ch][r] + rwc_pkg::RowSumW'(prod_ff[ch][r][c]);
            end
         end
      end
   end

   always_comb begin
      total  = '0;
      scaled = '0;
      for (int ch = 0; ch < 3; ch++) begin
         total = '0;
         for (int r = 0; r < Kh; r++) begin
            total = total + rwc_pkg::SumW'(rsum_ff[ch][r]);
         end
         scaled = total[rwc_pkg::SumW-1:rwc_pkg::CoefFracBits];
         // saturate to the pixel range
         if (scaled > (rwc_pkg::SumW-rwc_pkg::CoefFracBits)'(255)) begin
            res_in[ch] = '1;
         end else begin
            res_in[ch] = scaled[rwc_pkg::ChanW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff <= 1'b0;
         s_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else if (en) begin
         m_v_ff <= q_valid;
         s_v_ff <= m_v_ff;
         o_v_ff <= s_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff   <= prod_in;
         m_last_ff <= q_head.last;
         rsum_ff   <= rsum_in;
         s_last_ff <= m_last_ff;
         res_ff    <= res_in;
         o_last_ff <= s_last_ff;
      end
   end

   assign out_valid = o_v_ff;
   assign out_data  = {res_ff[0], res_ff[1], res_ff[2]};
   assign out_last  = o_last_ff;

endmodule

>>> src/rwc_checker.sv
module rwc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               req_tuser,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [23:0]                        rsp_tdata,
   input logic                               rsp_tlast
);

   logic pix_acc, load_acc;

   assign pix_acc  = req_tvalid && req_tready &&
                     (rwc_pkg::cmd_type'(req_tuser) == rwc_pkg::CMD_PIXEL);
   assign load_acc = req_tvalid && req_tready &&
                     (rwc_pkg::cmd_type'(req_tuser) == rwc_pkg::CMD_LOAD);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result right after reset");

   // a load never follows a pixel request in the very next cycle
   assert property (@(posedge clock) disable iff (reset)
      load_acc |-> $past(reset) || !$past(pix_acc))
      else $error("load overtook a pixel");

   // no request taken while reset is applied
   assert property (@(posedge clock) reset |-> !req_tready)
      else $error("request taken in reset");

endmodule

bind rgb_window_convolution_valid rwc_checker u_rwc_checker (.*);

>>> dv/tb_top.sv
module tb_top;

   // one filtered output pixel as it should appear on rsp
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
   } blur_pix_type;

   // directed stimulus row; want used only where chk is set
   typedef struct {
      rwc_pkg::cmd_type cmd;
      logic [4:0]       idx;
      logic [15:0]      coef;
      logic [7:0]       r, g, b;
      bit               chk;
      blur_pix_type     want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // coef_index, coef_value, red_in, green_in, blue_in
   logic        req_tuser = 1'b0; // command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // red_out, green_out, blue_out
   logic        rsp_tlast;        // frame_last
   logic        csr_we = 1'b0;
   logic        csr_addr = 1'b0;
   logic [rwc_pkg::HeightRegW-1:0] csr_wdata = '0;

   always #6 clock = ~clock;

   rgb_window_convolution_valid DUT (.*);

   // ---------------------------------------------------------------
   // shadow copy of the filter state
   // ---------------------------------------------------------------
   logic [rwc_pkg::WidthRegW-1:0]  width_reg  = 11'd1024;
   logic [rwc_pkg::HeightRegW-1:0] height_reg = 13'd1024;
   logic [rwc_pkg::CoefW-1:0]      kernel_tap [rwc_pkg::Taps];
   rwc_pkg::pix_type line_mem [rwc_pkg::KernelHeight-1][rwc_pkg::MaxWidth] =
      '{default: '0};
   rwc_pkg::pix_type win [rwc_pkg::KernelHeight][rwc_pkg::KernelWidth] =
      '{default: '0};
   int unsigned           col_pos = 0;
   int unsigned           row_pos = 0;

   blur_pix_type blur_q[$];

   int errors = 0;
   int results_seen = 0;
   int pixels_sent = 0;
   int loads_sent = 0;
   int frames_run = 0;

   // idle percentages of each side, changed per phase
   int snd_idle_pct = 0;
   int rcv_idle_pct = 0;
   int hold_asked = 0;
   int hold_served = 0;
   int hold_left = 0;

   function automatic int unsigned eff_w();
      if (width_reg == 0) return 1;
      if (width_reg > rwc_pkg::MaxWidth) return rwc_pkg::MaxWidth;
      return width_reg;
   endfunction

   function automatic int unsigned eff_h();
      if (height_reg == 0) return 1;
      if (height_reg > rwc_pkg::MaxHeight) return rwc_pkg::MaxHeight;
      return height_reg;
   endfunction

   function automatic logic [7:0] clip_chan(longint unsigned acc);
      longint unsigned v;
      v = acc >> rwc_pkg::CoefFracBits;
      return (v > 255) ? 8'd255 : v[7:0];
   endfunction

   // advance the filter by one accepted request; returns 1 when a window
   // completes, with the filtered pixel in px
   function automatic bit blur_step(rwc_pkg::cmd_type cmd, logic [47:0] d,
                                    output blur_pix_type px);
      rwc_pkg::pix_type vec [rwc_pkg::KernelHeight];
      int unsigned     w, h;
      longint unsigned ar, ag, ab, k;
      bit              hit;
      w = eff_w();
      h = eff_h();
      hit = 0;
      px = '0;
      if (cmd == rwc_pkg::CMD_LOAD) begin
         if (d[4:0] < rwc_pkg::Taps) kernel_tap[d[4:0]] = d[20:5];
         return 0;
      end
      for (int r = 0; r < rwc_pkg::KernelHeight - 1; r++) vec[r] = line_mem[r][col_pos];
      vec[rwc_pkg::KernelHeight-1] = {d[28:21], d[36:29], d[44:37]};
      for (int r = 0; r < rwc_pkg::KernelHeight - 1; r++) line_mem[r][col_pos] = vec[r+1];
      for (int r = 0; r < rwc_pkg::KernelHeight; r++) begin
         for (int c = 0; c < rwc_pkg::KernelWidth - 1; c++) win[r][c] = win[r][c+1];
         win[r][rwc_pkg::KernelWidth-1] = vec[r];
      end
      if (col_pos < w && row_pos < h && col_pos >= rwc_pkg::KernelWidth - 1 &&
          row_pos >= rwc_pkg::KernelHeight - 1) begin
         ar = 0; ag = 0; ab = 0;
         for (int r = 0; r < rwc_pkg::KernelHeight; r++)
            for (int c = 0; c < rwc_pkg::KernelWidth; c++) begin
               k  = kernel_tap[r*rwc_pkg::KernelWidth + c];
               ar += k * win[r][c][23:16];
               ag += k * win[r][c][15:8];
               ab += k * win[r][c][7:0];
            end
         px.red   = clip_chan(ar);
         px.green = clip_chan(ag);
         px.blue  = clip_chan(ab);
         px.last  = (col_pos == w - 1 && row_pos == h - 1);
         hit = 1;
      end
      if (col_pos + 1 >= w) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= h) ? 0 : (row_pos + 1) & 12'hfff;
      end else begin
         col_pos = (col_pos + 1) & 10'h3ff;
      end
      return hit;
   endfunction

   function automatic logic [47:0] pack_req(logic [4:0] idx, logic [15:0] coef,
                                            logic [7:0] r, logic [7:0] g, logic [7:0] b);
      return {3'b000, b, g, r, coef, idx};
   endfunction

   task automatic report_mismatch(string what);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   // ---------------------------------------------------------------
   // request driver: idle cycles at the sender's rate, then hold until taken
   // ---------------------------------------------------------------
   task automatic send_req(rwc_pkg::cmd_type cmd, logic [47:0] d, bit typed = 0,
                           blur_pix_type typed_px = '0);
      blur_pix_type px;
      while (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      // request taken at this edge
      if (cmd == rwc_pkg::CMD_PIXEL) pixels_sent++;
      else loads_sent++;
      if (blur_step(cmd, d, px)) blur_q.push_back(typed ? typed_px : px);
   endtask

   task automatic send_pixel();
      send_req(rwc_pkg::CMD_PIXEL, pack_req(5'($urandom), 16'($urandom), 8'($urandom),
                                            8'($urandom), 8'($urandom)));
   endtask

   task automatic send_load(int idx, logic [15:0] coef);
      // pixel fields are don't-care on a load, so they carry noise
      send_req(rwc_pkg::CMD_LOAD, pack_req(5'(idx), coef, 8'($urandom), 8'($urandom),
                                           8'($urandom)));
   endtask

   // drop valid and wait for the pipe to drain, plus the block latency
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (blur_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(rwc_pkg::reg_type idx, logic [rwc_pkg::HeightRegW-1:0] v);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == rwc_pkg::REG_WIDTH) width_reg = v[rwc_pkg::WidthRegW-1:0];
      else height_reg = v;
      @(posedge clock);
   endtask

   // kernel flavors: tiny weights, full-range weights (saturates) or one hot tap
   task automatic load_kernel();
      int kind;
      int hot;
      kind = $urandom_range(2);
      hot  = $urandom_range(rwc_pkg::Taps - 1);
      for (int t = 0; t < rwc_pkg::Taps; t++) begin
         case (kind)
            0: send_load(t, 16'($urandom_range(2621)));
            1: send_load(t, 16'($urandom));
            default: begin
               send_load(t, (t == hot) ? 16'hffff : 16'h0000);
            end
         endcase
      end
   endtask

   // one full frame in raster order with occasional loads mixed in
   task automatic run_frame(int load_pct);
      int unsigned n;
      n = eff_w() * eff_h();
      for (int unsigned i = 0; i < n; i++) begin
         if ($urandom_range(99) < load_pct) send_load($urandom_range(31), 16'($urandom));
         send_pixel();
      end
      frames_run++;
   endtask

   // ---------------------------------------------------------------
   // receiver ready: random stalls, or a long hold-off when asked
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_served != hold_asked) begin
         hold_served <= hold_asked;
         hold_left   <= 300;
         rsp_tready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (rcv_idle_pct == 0) || ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   // ---------------------------------------------------------------
   // result checker
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      blur_pix_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (blur_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h last %b", rsp_tdata, rsp_tlast));
         end else begin
            want = blur_q.pop_front();
            if (rsp_tdata[7:0] !== want.red)
               report_mismatch($sformatf("red %h want %h", rsp_tdata[7:0], want.red));
            if (rsp_tdata[15:8] !== want.green)
               report_mismatch($sformatf("green %h want %h", rsp_tdata[15:8], want.green));
            if (rsp_tdata[23:16] !== want.blue)
               report_mismatch($sformatf("blue %h want %h", rsp_tdata[23:16], want.blue));
            if (rsp_tlast !== want.last)
               report_mismatch($sformatf("last %b want %b", rsp_tlast, want.last));
         end
      end
   end

   // ---------------------------------------------------------------
   // watchdog: too long with no handshake on either side
   // ---------------------------------------------------------------
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= 3000) begin
         $display("tb_top NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------
   stim_row_type dir_tab [26];

   initial begin
      int mode;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: 5x5 image, kernel picks only the oldest pixel of the window
      csr_write(rwc_pkg::REG_WIDTH, 13'd5);
      csr_write(rwc_pkg::REG_HEIGHT, 13'd5);
      for (int t = 0; t < rwc_pkg::Taps; t++) send_load(t, (t == 0) ? 16'hffff : 16'h0000);

      // out-of-range tap index must be ignored
      dir_tab[0] = '{rwc_pkg::CMD_LOAD, 5'd31, 16'hffff, 8'hff, 8'hff, 8'hff, 0, '0};
      for (int i = 1; i < 26; i++) begin
         dir_tab[i] = '{rwc_pkg::CMD_PIXEL, 5'($urandom), 16'($urandom),
                        8'($urandom), 8'($urandom), 8'($urandom), 0, '0};
      end
      dir_tab[1].r = 8'hff; dir_tab[1].g = 8'h00; dir_tab[1].b = 8'h80;
      dir_tab[2].r = 8'h00; dir_tab[2].g = 8'hff; dir_tab[2].b = 8'h00;
      // single output: pixel (0,0) times 0xffff/0x10000, last of the frame
      dir_tab[25].chk  = 1;
      dir_tab[25].want = '{8'd254, 8'd0, 8'd127, 1'b1};
      foreach (dir_tab[i])
         send_req(dir_tab[i].cmd,
                  pack_req(dir_tab[i].idx, dir_tab[i].coef, dir_tab[i].r,
                           dir_tab[i].g, dir_tab[i].b),
                  dir_tab[i].chk, dir_tab[i].want);
      drain();

      // image smaller than the kernel, zero width/height acting as one
      csr_write(rwc_pkg::REG_WIDTH, 13'd0);
      csr_write(rwc_pkg::REG_HEIGHT, 13'd3);
      run_frame(0);
      drain();
      csr_write(rwc_pkg::REG_WIDTH, 13'd4);
      csr_write(rwc_pkg::REG_HEIGHT, 13'd0);
      run_frame(0);
      drain();

      // random frames, three idling phases
      while (pixels_sent < 600) begin
         mode = (pixels_sent < 240) ? 0 : (pixels_sent < 420) ? 1 : 2;
         snd_idle_pct = (mode == 0) ? 12 : (mode == 1) ? 80 : 0;
         rcv_idle_pct = (mode == 0) ? 80 : (mode == 1) ? 12 : 0;
         // random upper bits on the width write exercise the masking
         csr_write(rwc_pkg::REG_WIDTH, {2'($urandom), ($urandom_range(9) == 0) ?
                   11'($urandom_range(4, 1)) : 11'($urandom_range(16, 5))});
         csr_write(rwc_pkg::REG_HEIGHT, ($urandom_range(9) == 0) ?
                   13'($urandom_range(4, 1)) : 13'($urandom_range(9, 5)));
         load_kernel();
         if (mode == 2 && $urandom_range(3) == 0) hold_asked++;
         run_frame(5);
         drain();
      end

      // long receiver hold-off over a frame with many outputs
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      csr_write(rwc_pkg::REG_WIDTH, 13'd16);
      csr_write(rwc_pkg::REG_HEIGHT, 13'd9);
      load_kernel();
      hold_asked++;
      run_frame(0);
      drain();

      // clamped oversize registers, then a size change in the middle of a frame
      csr_write(rwc_pkg::REG_WIDTH, 13'd2047);
      csr_write(rwc_pkg::REG_HEIGHT, 13'd8191);
      for (int i = 0; i < 64; i++) send_pixel();
      drain();
      csr_write(rwc_pkg::REG_WIDTH, 13'd5);
      csr_write(rwc_pkg::REG_HEIGHT, 13'd5);
      load_kernel();
      run_frame(0);
      drain();
      repeat (20) @(posedge clock);

      $display("covered %0d frames, %0d pixels, %0d coefficient loads, %0d outputs",
               frames_run, pixels_sent, loads_sent, results_seen);
      $display("tiny to 16 wide images, clamped sizes, mid-frame resize, long stalls");
      if (errors == 0 && blur_q.size() == 0) begin
         $display("tb_top OK");
      end else begin
         if (blur_q.size() != 0) $display("%0d outputs never arrived", blur_q.size());
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

>>> files.f
src/rwc_pkg.sv
src/rwc_front.sv
src/rwc_queue.sv
src/rwc_back.sv
src/rgb_window_convolution_valid.sv
src/rwc_checker.sv
dv/tb_top.sv
